// ===== hdl/tls_pkg.sv =====
`default_nettype none
// ============================================================================
// tls_pkg - task list scheduler shared definitions
// Sizes, request and status codes, and the list store command and status.
// ============================================================================
package tls_pkg;

    localparam int MAX_TASKS = 16;
    localparam int NUM_W     = 16;
    localparam int TIME_W    = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0,
        ACT_KILL   = 3'd1,
        ACT_HALT   = 3'd2,
        ACT_SETD   = 3'd3,
        ACT_TICK   = 3'd4,
        ACT_RUN    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        LIST_READY = 2'd0,
        LIST_SLEEP = 2'd1,
        LIST_HALT  = 2'd2,
        LIST_BAD   = 2'd3
    } t_list;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NFOUND = 3'd1,
        ST_FULL   = 3'd2,
        ST_BADLST = 3'd3,
        ST_NONE   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_R,
        S_SCAN_S,
        S_SCAN_H,
        S_EXEC,
        S_WAKE,
        S_EMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              app_r;
        logic              app_s;
        logic              app_h;
        logic [NUM_W-1:0]  app_num;
        logic [TIME_W-1:0] app_dur;
        logic [TIME_W-1:0] app_start;
        logic              drop_r;
        logic              drop_s;
        logic              drop_h;
        logic [IDX_W-1:0]  drop_idx;
        logic              set_s;
        logic [IDX_W-1:0]  set_idx;
        logic [IDX_W-1:0]  rd_idx;
    } t_store_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  ready_count;
        logic [CNT_W-1:0]  sleep_count;
        logic [CNT_W-1:0]  halt_count;
        logic [NUM_W-1:0]  ready_num;
        logic [NUM_W-1:0]  sleep_num;
        logic [NUM_W-1:0]  halt_num;
        logic [TIME_W-1:0] sleep_dur;
        logic [TIME_W-1:0] sleep_start;
    } t_store_stat;

endpackage
`default_nettype wire

// ===== hdl/tls_if.sv =====
`default_nettype none
// ============================================================================
// tls_if - request and result channels
// Valid/ready channels carrying one request or one result.
// ============================================================================
interface tls_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] task_number;
    logic [1:0]  start_list;
    logic [31:0] delay_value;

    modport source (output valid, action, task_number, start_list, delay_value,
                    input ready);
    modport sink   (input valid, action, task_number, start_list, delay_value,
                    output ready);
endinterface

interface tls_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_task;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, result_task, status, last, input ready);
    modport sink   (input valid, result_task, status, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/tls_cmp.sv =====
`default_nettype none
// ============================================================================
// tls_cmp - shared compare unit
// Number match for list searches and sleep expiry test for wakeups.
// ============================================================================
module tls_cmp
    import tls_pkg::*;
(
    input  wire logic [NUM_W-1:0]  i_a,
    input  wire logic [NUM_W-1:0]  i_b,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire logic [TIME_W-1:0] i_start,
    input  wire logic [TIME_W-1:0] i_dur,
    output logic                   o_eq,
    output logic                   o_expired
);
    logic [TIME_W-1:0] elapsed;

    // match entry against addressed task
    assign o_eq = (i_a == i_b);

    // elapsed time wraps modulo the counter width
    assign elapsed   = i_now - i_start;
    assign o_expired = (elapsed >= i_dur);
endmodule
`default_nettype wire

// ===== hdl/tls_store.sv =====
`default_nettype none
// ============================================================================
// tls_store - ordered task list store
// Ready, sleeping and halted lists with append, drop-and-close and update.
// ============================================================================
module tls_store
    import tls_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_store_cmd i_cmd,
    output t_store_stat     o_stat
);
    logic [NUM_W-1:0]  r_ready [MAX_TASKS];
    logic [NUM_W-1:0]  r_halt  [MAX_TASKS];
    logic [NUM_W-1:0]  r_snum  [MAX_TASKS];
    logic [TIME_W-1:0] r_sdur  [MAX_TASKS];
    logic [TIME_W-1:0] r_sst   [MAX_TASKS];
    logic [CNT_W-1:0]  r_rcnt, r_scnt, r_hcnt;
    logic [CNT_W-1:0]  n_rcnt, n_scnt, n_hcnt;

    // update counts
    always_comb begin
        n_rcnt = r_rcnt + CNT_W'(i_cmd.app_r) - CNT_W'(i_cmd.drop_r);
        n_scnt = r_scnt + CNT_W'(i_cmd.app_s) - CNT_W'(i_cmd.drop_s);
        n_hcnt = r_hcnt + CNT_W'(i_cmd.app_h) - CNT_W'(i_cmd.drop_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt <= '0;
            r_scnt <= '0;
            r_hcnt <= '0;
        end else begin
            r_rcnt <= n_rcnt;
            r_scnt <= n_scnt;
            r_hcnt <= n_hcnt;
        end
    end

    // shift entries down over a dropped slot, append at the tail
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_TASKS; j++) begin
            if (j < MAX_TASKS - 1) begin
                if (i_cmd.drop_r && IDX_W'(j) >= i_cmd.drop_idx)
                    r_ready[j] <= r_ready[j+1];
                if (i_cmd.drop_h && IDX_W'(j) >= i_cmd.drop_idx)
                    r_halt[j] <= r_halt[j+1];
                if (i_cmd.drop_s && IDX_W'(j) >= i_cmd.drop_idx) begin
                    r_snum[j] <= r_snum[j+1];
                    r_sdur[j] <= r_sdur[j+1];
                    r_sst[j]  <= r_sst[j+1];
                end
            end
            if (i_cmd.app_r && r_rcnt == CNT_W'(j))
                r_ready[j] <= i_cmd.app_num;
            if (i_cmd.app_h && r_hcnt == CNT_W'(j))
                r_halt[j] <= i_cmd.app_num;
            if (i_cmd.app_s && r_scnt == CNT_W'(j)) begin
                r_snum[j] <= i_cmd.app_num;
                r_sdur[j] <= i_cmd.app_dur;
                r_sst[j]  <= i_cmd.app_start;
            end
            if (i_cmd.set_s && i_cmd.set_idx == IDX_W'(j)) begin
                r_sdur[j] <= i_cmd.app_dur;
                r_sst[j]  <= i_cmd.app_start;
            end
        end
    end

    // read one entry of each list
    always_comb begin
        o_stat.ready_count = r_rcnt;
        o_stat.sleep_count = r_scnt;
        o_stat.halt_count  = r_hcnt;
        o_stat.ready_num   = r_ready[i_cmd.rd_idx];
        o_stat.sleep_num   = r_snum[i_cmd.rd_idx];
        o_stat.halt_num    = r_halt[i_cmd.rd_idx];
        o_stat.sleep_dur   = r_sdur[i_cmd.rd_idx];
        o_stat.sleep_start = r_sst[i_cmd.rd_idx];
    end
endmodule
`default_nettype wire

// ===== hdl/task_list_scheduler_core.sv =====
`default_nettype none
// Flow: create and tick go straight to execute and output; kill, halt and set
// delay first search the ready, sleeping and halted lists in turn, each search
// stopping at its first match, then execute. Run walks the sleeping list, then
// emits each ready task as one result. One request at a time; ready is held low
// until the last result is taken.
// Reset (synchronous, active low) empties all lists and clears time and numbering.
// ============================================================================
// task_list_scheduler_core - cooperative task list scheduler
// Sequencer walking three task lists through one shared compare unit.
// ============================================================================
module task_list_scheduler_core
    import tls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tls_in_if.sink     i_req,
    tls_out_if.source  o_res
);
    t_state            r_state, n_state;
    t_action           r_act, n_act;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [1:0]        r_list, n_list;
    logic [TIME_W-1:0] r_dly, n_dly;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_rf, n_rf, r_sf, n_sf, r_hf, n_hf;
    logic [IDX_W-1:0]  r_ri, n_ri, r_si, n_si, r_hi, n_hi;
    logic [NUM_W-1:0]  r_next, n_next;
    logic [TIME_W-1:0] r_time, n_time;
    logic              r_ov, n_ov;
    logic [NUM_W-1:0]  r_otask, n_otask;
    t_status           r_ost, n_ost;
    logic              r_olast, n_olast;

    t_store_cmd        cmd;
    t_store_stat       st;
    logic [NUM_W-1:0]  cur_num;
    logic [CNT_W-1:0]  cur_cnt;
    logic              in_range, eq, expired, scan_done;

    tls_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (st)
    );

    tls_cmp u_cmp (
        .i_a       (cur_num),
        .i_b       (r_num),
        .i_now     (r_time),
        .i_start   (st.sleep_start),
        .i_dur     (st.sleep_dur),
        .o_eq      (eq),
        .o_expired (expired)
    );

    // select the list under search
    always_comb begin
        unique case (r_state)
            S_SCAN_S: begin
                cur_num = st.sleep_num;
                cur_cnt = st.sleep_count;
            end
            S_SCAN_H: begin
                cur_num = st.halt_num;
                cur_cnt = st.halt_count;
            end
            S_WAKE: begin
                cur_num = st.sleep_num;
                cur_cnt = st.sleep_count;
            end
            default: begin
                cur_num = st.ready_num;
                cur_cnt = st.ready_count;
            end
        endcase
    end

    assign in_range  = (r_idx < cur_cnt);
    assign scan_done = !in_range || eq;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.result_task = r_otask;
    assign o_res.status      = r_ost;
    assign o_res.last        = r_olast;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    priority case (t_action'(i_req.action))
                        ACT_CREATE, ACT_TICK:          n_state = S_EXEC;
                        ACT_KILL, ACT_HALT, ACT_SETD:  n_state = S_SCAN_R;
                        ACT_RUN:                       n_state = S_WAKE;
                        default:                       n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN_R: if (scan_done) n_state = S_SCAN_S;
            S_SCAN_S: if (scan_done) n_state = S_SCAN_H;
            S_SCAN_H: if (scan_done) n_state = S_EXEC;
            S_EXEC:   n_state = S_OUT;
            S_WAKE: begin
                if (!in_range)
                    n_state = (st.ready_count == '0) ? S_OUT : S_EMIT;
            end
            S_EMIT:   n_state = S_OUT;
            S_OUT: begin
                if (o_res.ready)
                    n_state = r_olast ? S_IDLE : S_EMIT;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and list commands
    always_comb begin
        n_act   = r_act;
        n_num   = r_num;
        n_list  = r_list;
        n_dly   = r_dly;
        n_idx   = r_idx;
        n_rf    = r_rf;
        n_sf    = r_sf;
        n_hf    = r_hf;
        n_ri    = r_ri;
        n_si    = r_si;
        n_hi    = r_hi;
        n_next  = r_next;
        n_time  = r_time;
        n_ov    = r_ov;
        n_otask = r_otask;
        n_ost   = r_ost;
        n_olast = r_olast;
        cmd           = '0;
        cmd.rd_idx    = r_idx[IDX_W-1:0];
        cmd.app_start = r_time;
        cmd.app_dur   = r_dly;
        cmd.app_num   = r_num;
        unique case (r_state)
            S_IDLE: begin
                // latch the request
                if (i_req.valid) begin
                    n_act  = t_action'(i_req.action);
                    n_num  = i_req.task_number;
                    n_list = i_req.start_list;
                    n_dly  = i_req.delay_value;
                    n_idx  = '0;
                    n_rf   = 1'b0;
                    n_sf   = 1'b0;
                    n_hf   = 1'b0;
                end
            end
            S_SCAN_R, S_SCAN_S, S_SCAN_H: begin
                // record first match, advance otherwise
                if (in_range && eq) begin
                    unique case (r_state)
                        S_SCAN_R: begin n_rf = 1'b1; n_ri = r_idx[IDX_W-1:0]; end
                        S_SCAN_S: begin n_sf = 1'b1; n_si = r_idx[IDX_W-1:0]; end
                        default:  begin n_hf = 1'b1; n_hi = r_idx[IDX_W-1:0]; end
                    endcase
                    n_idx = '0;
                end else if (in_range) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_idx = '0;
                end
            end
            S_EXEC: begin
                n_ov    = 1'b1;
                n_olast = 1'b1;
                n_otask = r_num;
                n_ost   = ST_OK;
                priority case (r_act)
                    ACT_CREATE: begin
                        n_otask     = '0;
                        cmd.app_num = r_next;
                        if (t_list'(r_list) == LIST_BAD) begin
                            n_ost = ST_BADLST;
                        end else if ((t_list'(r_list) == LIST_READY && st.ready_count >= MAX_CNT)
                                  || (t_list'(r_list) == LIST_SLEEP && st.sleep_count >= MAX_CNT)
                                  || (t_list'(r_list) == LIST_HALT  && st.halt_count  >= MAX_CNT))
                        begin
                            n_ost = ST_FULL;
                        end else begin
                            cmd.app_r = (t_list'(r_list) == LIST_READY);
                            cmd.app_s = (t_list'(r_list) == LIST_SLEEP);
                            cmd.app_h = (t_list'(r_list) == LIST_HALT);
                            n_otask   = r_next;
                            n_next    = r_next + 1'b1;
                        end
                    end
                    ACT_KILL: begin
                        if (r_rf) begin
                            cmd.drop_r = 1'b1; cmd.drop_idx = r_ri;
                        end else if (r_sf) begin
                            cmd.drop_s = 1'b1; cmd.drop_idx = r_si;
                        end else if (r_hf) begin
                            cmd.drop_h = 1'b1; cmd.drop_idx = r_hi;
                        end else begin
                            n_ost = ST_NFOUND;
                        end
                    end
                    ACT_HALT: begin
                        if (!r_rf && !r_sf) begin
                            n_ost = ST_NFOUND;
                        end else if (st.halt_count >= MAX_CNT) begin
                            n_ost = ST_FULL;
                        end else begin
                            cmd.app_h    = 1'b1;
                            cmd.drop_r   = r_rf;
                            cmd.drop_s   = !r_rf;
                            cmd.drop_idx = r_rf ? r_ri : r_si;
                        end
                    end
                    ACT_SETD: begin
                        if (r_rf || r_hf) begin
                            if (st.sleep_count >= MAX_CNT) begin
                                n_ost = ST_FULL;
                            end else begin
                                cmd.app_s    = 1'b1;
                                cmd.drop_r   = r_rf;
                                cmd.drop_h   = !r_rf;
                                cmd.drop_idx = r_rf ? r_ri : r_hi;
                            end
                        end else if (r_sf) begin
                            cmd.set_s   = 1'b1;
                            cmd.set_idx = r_si;
                        end else begin
                            n_ost = ST_NFOUND;
                        end
                    end
                    default: begin
                        // tick
                        n_otask = '0;
                        n_time  = r_time + 1'b1;
                    end
                endcase
            end
            S_WAKE: begin
                // move expired sleepers to ready while it has room, keep place after a drop
                if (in_range) begin
                    if (expired && st.ready_count < MAX_CNT) begin
                        cmd.app_r    = 1'b1;
                        cmd.app_num  = st.sleep_num;
                        cmd.drop_s   = 1'b1;
                        cmd.drop_idx = r_idx[IDX_W-1:0];
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_idx = '0;
                    if (st.ready_count == '0) begin
                        n_ov    = 1'b1;
                        n_otask = '0;
                        n_ost   = ST_NONE;
                        n_olast = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                n_ov    = 1'b1;
                n_otask = st.ready_num;
                n_ost   = ST_OK;
                n_olast = ((r_idx + 1'b1) == st.ready_count);
            end
            S_OUT: begin
                // hold the result until taken
                if (o_res.ready) begin
                    n_ov = 1'b0;
                    if (!r_olast)
                        n_idx = r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_next  <= '0;
            r_time  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_next  <= n_next;
            r_time  <= n_time;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_num   <= n_num;
        r_list  <= n_list;
        r_dly   <= n_dly;
        r_idx   <= n_idx;
        r_rf    <= n_rf;
        r_sf    <= n_sf;
        r_hf    <= n_hf;
        r_ri    <= n_ri;
        r_si    <= n_si;
        r_hi    <= n_hi;
        r_otask <= n_otask;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

`ifndef ASSERT_OFF
    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov == (r_state == S_OUT))
        else $error("result valid outside output state");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_res.valid)
        else $error("request taken while a result waits");
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.ready_count <= MAX_CNT && st.sleep_count <= MAX_CNT
        && st.halt_count <= MAX_CNT)
        else $error("list count beyond capacity");
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_act == ACT_TICK) |=> r_time == $past(r_time) + 1'b1)
        else $error("tick did not advance time");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_task_list_scheduler_core.sv =====
`default_nettype none
// ============================================================================
// tb_task_list_scheduler_core - task list scheduler testbench
// Drives create, kill, halt, set delay, tick, run and undefined action requests with random
// gaps on both channels. A behavioral model of the three task lists predicts
// every result, and a checker compares each result in order.
// ============================================================================
module tb_task_list_scheduler_core;
    import tls_pkg::*;

    typedef struct packed {
        logic [15:0] task_id;
        logic [2:0]  status;
        logic        last;
    } t_result;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    tls_in_if  req_ch ();
    tls_out_if res_ch ();

    task_list_scheduler_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // model state of the three lists
    logic [NUM_W-1:0]  rdy_q[$];
    logic [NUM_W-1:0]  hlt_q[$];
    logic [NUM_W-1:0]  slp_num_q[$];
    logic [TIME_W-1:0] slp_dur_q[$];
    logic [TIME_W-1:0] slp_start_q[$];
    logic [NUM_W-1:0]  task_counter;
    logic [TIME_W-1:0] clock_units;

    t_result expected_results[$];
    int      error_count;
    int      idle_cycles;
    bit      stall_enable;
    int      stall_hold;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int find_task(ref logic [NUM_W-1:0] q[$], input logic [NUM_W-1:0] n);
        for (int i = 0; i < q.size(); i++) begin
            if (q[i] == n) return i;
        end
        return -1;
    endfunction

    function automatic void push_result(logic [15:0] t, t_status s, logic l);
        t_result r;
        r.task_id = t;
        r.status  = s;
        r.last    = l;
        expected_results.push_back(r);
    endfunction

    function automatic void drop_sleeper(int i);
        slp_num_q.delete(i);
        slp_dur_q.delete(i);
        slp_start_q.delete(i);
    endfunction

    function automatic void add_sleeper(logic [NUM_W-1:0] n, logic [TIME_W-1:0] d);
        slp_num_q.push_back(n);
        slp_dur_q.push_back(d);
        slp_start_q.push_back(clock_units);
    endfunction

    // predict the results of one accepted request
    function automatic void predict_schedule(logic [2:0] act, logic [15:0] n,
                                             logic [1:0] lst, logic [31:0] dly);
        int ri;
        int si;
        int hi;
        int k;
        case (act)
            ACT_CREATE: begin
                if (lst == LIST_BAD) begin
                    push_result('0, ST_BADLST, 1'b1);
                end else if ((lst == LIST_READY && rdy_q.size() >= MAX_TASKS) ||
                             (lst == LIST_SLEEP && slp_num_q.size() >= MAX_TASKS) ||
                             (lst == LIST_HALT && hlt_q.size() >= MAX_TASKS)) begin
                    push_result('0, ST_FULL, 1'b1);
                end else begin
                    if (lst == LIST_READY) rdy_q.push_back(task_counter);
                    else if (lst == LIST_SLEEP) add_sleeper(task_counter, dly);
                    else hlt_q.push_back(task_counter);
                    push_result(task_counter, ST_OK, 1'b1);
                    task_counter++;
                end
            end
            ACT_KILL: begin
                ri = find_task(rdy_q, n);
                si = find_task(slp_num_q, n);
                hi = find_task(hlt_q, n);
                if (ri >= 0) begin
                    rdy_q.delete(ri);
                    push_result(n, ST_OK, 1'b1);
                end else if (si >= 0) begin
                    drop_sleeper(si);
                    push_result(n, ST_OK, 1'b1);
                end else if (hi >= 0) begin
                    hlt_q.delete(hi);
                    push_result(n, ST_OK, 1'b1);
                end else begin
                    push_result(n, ST_NFOUND, 1'b1);
                end
            end
            ACT_HALT: begin
                ri = find_task(rdy_q, n);
                si = find_task(slp_num_q, n);
                if (ri < 0 && si < 0) begin
                    push_result(n, ST_NFOUND, 1'b1);
                end else if (hlt_q.size() >= MAX_TASKS) begin
                    push_result(n, ST_FULL, 1'b1);
                end else begin
                    hlt_q.push_back(n);
                    if (ri >= 0) rdy_q.delete(ri);
                    else drop_sleeper(si);
                    push_result(n, ST_OK, 1'b1);
                end
            end
            ACT_SETD: begin
                ri = find_task(rdy_q, n);
                hi = find_task(hlt_q, n);
                si = find_task(slp_num_q, n);
                if (ri >= 0 || hi >= 0) begin
                    if (slp_num_q.size() >= MAX_TASKS) begin
                        push_result(n, ST_FULL, 1'b1);
                    end else begin
                        add_sleeper(n, dly);
                        if (ri >= 0) rdy_q.delete(ri);
                        else hlt_q.delete(hi);
                        push_result(n, ST_OK, 1'b1);
                    end
                end else if (si >= 0) begin
                    slp_dur_q[si]   = dly;
                    slp_start_q[si] = clock_units;
                    push_result(n, ST_OK, 1'b1);
                end else begin
                    push_result(n, ST_NFOUND, 1'b1);
                end
            end
            ACT_TICK: begin
                clock_units++;
                push_result('0, ST_OK, 1'b1);
            end
            ACT_RUN: begin
                // wake expired sleepers in list order while ready has room
                k = 0;
                while (k < slp_num_q.size()) begin
                    if (TIME_W'(clock_units - slp_start_q[k]) >= slp_dur_q[k] &&
                        rdy_q.size() < MAX_TASKS) begin
                        rdy_q.push_back(slp_num_q[k]);
                        drop_sleeper(k);
                    end else begin
                        k++;
                    end
                end
                if (rdy_q.size() == 0) begin
                    push_result('0, ST_NONE, 1'b1);
                end else begin
                    for (int i = 0; i < rdy_q.size(); i++)
                        push_result(rdy_q[i], ST_OK, i == rdy_q.size() - 1);
                end
            end
            default: ;
        endcase
    endfunction

    // send one request after a random gap, back to back when the gap is zero
    task automatic send_request(logic [2:0] act, logic [15:0] n, logic [1:0] lst,
                                logic [31:0] dly);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.task_number <= n;
        req_ch.start_list  <= lst;
        req_ch.delay_value <= dly;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_schedule(act, n, lst, dly);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_task();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3 && rdy_q.size() > 0) return rdy_q[$urandom_range(0, rdy_q.size() - 1)];
        if (sel < 6 && slp_num_q.size() > 0)
            return slp_num_q[$urandom_range(0, slp_num_q.size() - 1)];
        if (sel < 8 && hlt_q.size() > 0) return hlt_q[$urandom_range(0, hlt_q.size() - 1)];
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom);
            default: return 32'($urandom_range(0, 6));
        endcase
    endfunction

    // receiver: random stalls plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold   <= stall_hold - 1;
            res_ch.ready <= 1'b0;
        end else if (res_ch.ready && res_ch.valid) begin
            res_ch.ready <= 1'b1;
        end else if (idle_cycles > 0) begin
            idle_cycles  <= idle_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            if (stall_enable) idle_cycles <= $urandom_range(0, 15);
        end
    end

    // check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result task=%0d status=%0d last=%0d", $time,
                         res_ch.result_task, res_ch.status, res_ch.last);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.task_id != res_ch.result_task || exp_r.status != res_ch.status ||
                    exp_r.last != res_ch.last) begin
                    $display("%0t mismatch expected task=%0d status=%0d last=%0d,",
                             $time, exp_r.task_id, exp_r.status, exp_r.last,
                             " actual task=%0d status=%0d last=%0d",
                             res_ch.result_task, res_ch.status, res_ch.last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        int quiet;
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // extremes, every action and every special case
    task automatic test_directed();
        send_request(ACT_RUN, '0, LIST_READY, '0);            // nothing ready
        send_request(ACT_CREATE, '0, LIST_BAD, 32'hFFFF_FFFF); // invalid list
        send_request(ACT_CREATE, '0, LIST_READY, '0);
        send_request(ACT_CREATE, '0, LIST_SLEEP, 32'd2);
        send_request(ACT_CREATE, '0, LIST_HALT, '0);
        send_request(ACT_CREATE, '0, LIST_SLEEP, 32'hFFFF_FFFF);
        send_request(ACT_HALT, 16'd2, LIST_READY, '0);        // already halted
        send_request(ACT_HALT, 16'hFFFF, LIST_BAD, '0);
        send_request(ACT_KILL, 16'hFFFF, LIST_READY, '0);
        send_request(ACT_RUN, '0, LIST_READY, '0);
        send_request(ACT_TICK, 16'hFFFF, LIST_BAD, 32'hFFFF_FFFF);
        send_request(ACT_TICK, '0, LIST_READY, '0);
        send_request(ACT_RUN, '0, LIST_READY, '0);            // wakes task 1
        send_request(ACT_SETD, 16'd3, LIST_READY, 32'd5);     // restart a sleeper
        send_request(ACT_SETD, '0, LIST_READY, '0);           // ready to sleep
        send_request(ACT_SETD, 16'd2, LIST_READY, 32'd1);     // halted to sleep
        send_request(ACT_HALT, '0, LIST_READY, '0);           // sleeper to halted
        send_request(ACT_KILL, 16'd2, LIST_READY, '0);
        send_request(ACT_KILL, '0, LIST_READY, '0);
        send_request(3'd6, 16'hFFFF, LIST_BAD, 32'hFFFF_FFFF); // ignored
        send_request(3'd7, '0, LIST_READY, '0);
        send_request(ACT_RUN, '0, LIST_READY, '0);
        wait_drained();
    endtask

    // fill lists to full with the receiver held off
    task automatic test_full_lists();
        stall_hold = 400;
        for (int i = 0; i < 17; i++) send_request(ACT_CREATE, '0, LIST_READY, '0);
        for (int i = 0; i < 17; i++) send_request(ACT_CREATE, '0, LIST_HALT, '0);
        for (int i = 0; i < 17; i++) send_request(ACT_CREATE, '0, LIST_SLEEP, '0);
        send_request(ACT_HALT, rdy_q[0], LIST_READY, '0);     // halted full
        send_request(ACT_SETD, rdy_q[1], LIST_READY, '0);     // sleeping full
        send_request(ACT_TICK, '0, LIST_READY, '0);
        send_request(ACT_RUN, '0, LIST_READY, '0);            // ready full, none wake
        send_request(ACT_KILL, rdy_q[0], LIST_READY, '0);
        send_request(ACT_RUN, '0, LIST_READY, '0);            // one wakes
        wait_drained();
    endtask

    // random mix biased toward existing tasks
    task automatic test_random_mix();
        int act;
        for (int i = 0; i < 75; i++) begin
            act = $urandom_range(0, 19);
            if (act < 5)       send_request(ACT_CREATE, 16'($urandom), 2'($urandom), pick_delay());
            else if (act < 8)  send_request(ACT_KILL, pick_task(), 2'($urandom), 32'($urandom));
            else if (act < 10) send_request(ACT_HALT, pick_task(), 2'($urandom), 32'($urandom));
            else if (act < 13) send_request(ACT_SETD, pick_task(), 2'($urandom), pick_delay());
            else if (act < 16) send_request(ACT_TICK, 16'($urandom), 2'($urandom), 32'($urandom));
            else if (act < 19) send_request(ACT_RUN, 16'($urandom), 2'($urandom), 32'($urandom));
            else send_request(3'($urandom_range(6, 7)), 16'($urandom), 2'($urandom), 32'($urandom));
            if (i == 35) stall_enable = 1'b0;
            if (i == 50) stall_enable = 1'b1;
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = '0;
        req_ch.task_number = '0;
        req_ch.start_list  = '0;
        req_ch.delay_value = '0;
        task_counter       = '0;
        clock_units        = '0;
        error_count        = 0;
        idle_cycles        = 0;
        stall_enable       = 1'b1;
        stall_hold         = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_lists();
        test_random_mix();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
